// ===== hw/rtl/tctw_pkg.sv =====
package tctw_pkg;

  // Default geometry
  localparam int DEF_COLUMNS            = 80;
  localparam int DEF_ROWS               = 25;
  localparam int DEF_FIRST_SCROLLED_ROW = 2;

  // Cell layout: low byte character, high byte attribute
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;

  // Item commands
  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_READ      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_COPY,
    ST_SCROLL_DRAIN,
    ST_SCROLL_FILL,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic exec;
    logic clear_wr;
    logic fill_wr;
    logic copy_rd;
    logic cnt_load_copy;
    logic cnt_inc;
    logic load_result;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scroll;
    logic cnt_copy_end;
    logic cnt_last;
    logic res_valid;
  } dp_status_t;

endpackage

// ===== hw/rtl/tctw_ram.sv =====
module tctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tctw_ctrl.sv =====
module tctw_ctrl import tctw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       res_stall,
  input  dp_status_t sts,
  output logic       cmd_stall,
  output ctrl_cmd_t  ctl
);

  state_t state, state_next;
  logic   out_free;

  // Result register can take a beat this cycle
  assign out_free = !sts.res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.need_scroll ? ST_SCROLL_COPY : ST_RESULT;
      end
      ST_SCROLL_COPY: begin
        if (sts.cnt_copy_end) state_next = ST_SCROLL_DRAIN;
      end
      ST_SCROLL_DRAIN: begin
        state_next = ST_SCROLL_FILL;
      end
      ST_SCROLL_FILL: begin
        if (sts.cnt_last) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = cmd_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    cmd_stall = 1'b1;
    case (state)
      ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        ctl.cnt_inc  = 1'b1;
      end
      ST_IDLE: begin
        cmd_stall     = 1'b0;
        ctl.take_item = cmd_valid;
      end
      ST_EXEC: begin
        ctl.exec          = 1'b1;
        ctl.cnt_load_copy = sts.need_scroll;
      end
      ST_SCROLL_COPY: begin
        ctl.copy_rd = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      ST_SCROLL_DRAIN: begin
        // last copied cell is written from the read register
      end
      ST_SCROLL_FILL: begin
        ctl.fill_wr = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      ST_RESULT: begin
        if (out_free) begin
          ctl.load_result = 1'b1;
          cmd_stall       = 1'b0;
          ctl.take_item   = cmd_valid;
        end
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tctw_dp.sv =====
module tctw_dp import tctw_pkg::*; #(
  parameter int COLUMNS            = DEF_COLUMNS,
  parameter int ROWS               = DEF_ROWS,
  parameter int FIRST_SCROLLED_ROW = DEF_FIRST_SCROLLED_ROW
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        res_stall,
  input  ctrl_cmd_t   ctl,
  output dp_status_t  sts,
  output logic        res_valid,
  output logic [4:0]  cursor_line,
  output logic [6:0]  cursor_col,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color,
  output logic        scrolled
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int COPY_FIRST = (FIRST_SCROLLED_ROW - 1) * COLUMNS;
  localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;

  logic [CHAR_W-1:0] text_color;
  cmd_t              item_cmd;
  logic [CHAR_W-1:0] item_char;
  logic [4:0]        item_row;
  logic [6:0]        item_col;
  logic [RW-1:0]     row, row_next;
  logic [CW-1:0]     col, col_next;
  logic [AW-1:0]     cnt;
  logic              copy_wr_valid;
  logic [AW-1:0]     copy_wr_addr;
  logic              scrolled_flag;
  logic              rd_hit;

  logic [RW-1:0]     cell_row;
  logic [CW-1:0]     cell_col;
  logic              cell_wr;
  logic [CHAR_W-1:0] cell_code;
  logic              need_scroll;
  logic              col_last, row_last;
  logic              rd_in_range;
  logic [AW-1:0]     cell_addr, rd_addr;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      item_cmd  <= cmd_t'(command);
      item_char <= char_code;
      item_row  <= read_row;
      item_col  <= read_col;
    end
  end

  // Cursor decode for the current item
  assign col_last = (col == CW'(COLUMNS - 1));
  assign row_last = (row == RW'(ROWS - 1));

  always_comb begin
    row_next    = row;
    col_next    = col;
    cell_row    = row;
    cell_col    = col;
    cell_wr     = 1'b0;
    cell_code   = item_char;
    need_scroll = 1'b0;
    case (item_cmd)
      CMD_PUT: begin
        if (item_char != NEWLINE_CODE) cell_wr = 1'b1;
        if (item_char == NEWLINE_CODE || col_last) begin
          col_next = '0;
          if (row_last) begin
            need_scroll = 1'b1;
          end else begin
            row_next = row + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        cell_code = BLANK_CODE;
        if (col != '0) begin
          col_next = col - 1'b1;
          cell_col = col - 1'b1;
          cell_wr  = 1'b1;
        end else if (row != '0) begin
          row_next = row - 1'b1;
          col_next = CW'(COLUMNS - 1);
          cell_row = row - 1'b1;
          cell_col = CW'(COLUMNS - 1);
          cell_wr  = 1'b1;
        end
      end
      default: begin
        cell_wr = 1'b0;
      end
    endcase
  end

  assign cell_addr   = AW'(cell_row) * AW'(COLUMNS) + AW'(cell_col);
  assign rd_in_range = (32'(item_row) < ROWS) && (32'(item_col) < COLUMNS);
  assign rd_addr     = AW'(item_row) * AW'(COLUMNS) + AW'(item_col);

  // Cursor and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (ctl.exec) begin
      row <= row_next;
      col <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      scrolled_flag <= need_scroll;
      rd_hit        <= (item_cmd == CMD_READ) && rd_in_range;
    end
  end

  // Sweep counter: clearing pass, scroll copy, then bottom-row fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.cnt_load_copy) begin
      cnt <= AW'(COPY_FIRST);
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Copy write comes in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr_valid <= 1'b0;
    end else begin
      copy_wr_valid <= ctl.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    copy_wr_addr <= cnt;
  end

  // Cell store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = {RESET_COLOR, BLANK_CODE};
    if (ctl.clear_wr) begin
      ram_we = 1'b1;
    end else if (ctl.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {text_color, BLANK_CODE};
    end else if (copy_wr_valid) begin
      ram_we    = 1'b1;
      ram_waddr = copy_wr_addr;
      ram_wdata = ram_rdata;
    end else if (ctl.exec && cell_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr;
      ram_wdata = {text_color, cell_code};
    end
  end

  assign ram_re    = ctl.copy_rd || (ctl.exec && item_cmd == CMD_READ && rd_in_range);
  assign ram_raddr = ctl.copy_rd ? cnt + AW'(COLUMNS) : rd_addr;

  tctw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      cursor_line <= 5'(row);
      cursor_col  <= 7'(col);
      cell_char   <= rd_hit ? ram_rdata[CHAR_W-1:0] : '0;
      cell_color  <= rd_hit ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      scrolled    <= scrolled_flag;
    end
  end

  // Status
  assign sts.need_scroll  = need_scroll;
  assign sts.cnt_copy_end = (cnt == AW'(COPY_LAST));
  assign sts.cnt_last     = (cnt == AW'(CELLS - 1));
  assign sts.res_valid    = res_valid;

endmodule

// ===== hw/rtl/text_console_teletype_writer_top.sv =====
// Teletype console over a COLUMNS x ROWS cell store (character byte plus attribute
// byte per cell). After reset the block runs a clearing pass over every cell with
// cmd_stall high; text_color writes are taken during it. Put, backspace and read
// items each first update the cursor and write or read the cell store, then load the
// result register, which also accepts the next beat. A put that runs off the bottom
// row scrolls, and every moved or blanked cell goes through the single write port of
// the cell store. Row 0 is never scrolled.
module text_console_teletype_writer_top import tctw_pkg::*; #(
  parameter int COLUMNS            = DEF_COLUMNS,
  parameter int ROWS               = DEF_ROWS,
  parameter int FIRST_SCROLLED_ROW = DEF_FIRST_SCROLLED_ROW
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [4:0] cursor_line,
  output logic [6:0] cursor_col,
  output logic [7:0] cell_char,
  output logic [7:0] cell_color,
  output logic       scrolled
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  tctw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  tctw_dp #(
    .COLUMNS            (COLUMNS),
    .ROWS               (ROWS),
    .FIRST_SCROLLED_ROW (FIRST_SCROLLED_ROW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .command     (command),
    .char_code   (char_code),
    .read_row    (read_row),
    .read_col    (read_col),
    .res_stall   (res_stall),
    .ctl         (ctl),
    .sts         (sts),
    .res_valid   (res_valid),
    .cursor_line (cursor_line),
    .cursor_col  (cursor_col),
    .cell_char   (cell_char),
    .cell_color  (cell_color),
    .scrolled    (scrolled)
  );

  // No beat is taken in the first cycle of the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> cmd_stall)
    else $error("item accepted before clearing pass");

  // A scroll leaves the cursor at column 0 of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (res_valid && scrolled) |-> (cursor_line == 5'(ROWS - 1) && cursor_col == '0))
    else $error("cursor not at bottom-left after scroll");

  // Reported cursor column stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(cursor_col) < COLUMNS))
    else $error("cursor column off screen");

endmodule

// ===== tb/text_console_teletype_writer_top_test.sv =====
`timescale 1ns / 1ps

module text_console_teletype_writer_top_test;
  import tctw_pkg::*;

  localparam int COLS        = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int FIRST_ROLL  = DEF_FIRST_SCROLLED_ROW;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 10_000_000;

  // One reply beat, in port order
  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       scr;
  } console_result_t;

  // One directed command; want is only used where typed is set
  typedef struct packed {
    cmd_t            cmd;
    logic [7:0]      ch;
    logic [4:0]      rr;
    logic [6:0]      rc;
    logic            typed;
    console_result_t want;
  } probe_t;

  localparam console_result_t NO_CHECK = '0;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [1:0] command   = 2'd0;
  logic [7:0] char_code = 8'd0;
  logic [4:0] read_row  = 5'd0;
  logic [6:0] read_col  = 7'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [4:0] cursor_line;
  logic [6:0] cursor_col;
  logic [7:0] cell_char;
  logic [7:0] cell_color;
  logic       scrolled;

  // Shadow console state
  logic [15:0]     screen_copy [COLS*ROWS];
  int              cur_row;
  int              cur_col;
  logic [7:0]      text_attr;
  console_result_t due_replies [$];
  console_result_t reply_want;

  int   fail_count     = 0;
  int   items_sent     = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_go        = 1'b0;
  logic hold_done      = 1'b0;
  int   hold_cnt       = 0;

  // Directed commands: reset contents, out-of-screen reads, underflow, wraps
  probe_t probes [23] = '{
    '{CMD_READ,      8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd0, BLANK_CODE, RESET_COLOR, 1'b0}},
    '{CMD_READ,      8'hFF, 5'd24, 7'd79,  1'b1, '{5'd0, 7'd0, BLANK_CODE, RESET_COLOR, 1'b0}},
    '{CMD_READ,      8'h00, 5'd25, 7'd0,   1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd0,  7'd80,  1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_BACKSPACE, 8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_NONE,      8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_PUT,       8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd1, 8'h00, 8'h00, 1'b0}},
    '{CMD_PUT,       8'hFF, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd2, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd0,  7'd0,   1'b0, NO_CHECK},
    '{CMD_READ,      8'h00, 5'd0,  7'd1,   1'b0, NO_CHECK},
    '{CMD_PUT,       NEWLINE_CODE, 5'd0, 7'd0, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_BACKSPACE, 8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd79, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd0,  7'd79,  1'b0, NO_CHECK},
    '{CMD_PUT,       8'h41, 5'd0,  7'd0,   1'b1, '{5'd1, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd0,  7'd79,  1'b0, NO_CHECK},
    '{CMD_PUT,       8'h42, 5'd0,  7'd0,   1'b1, '{5'd1, 7'd1, 8'h00, 8'h00, 1'b0}},
    '{CMD_BACKSPACE, 8'h00, 5'd0,  7'd0,   1'b1, '{5'd1, 7'd0, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd1,  7'd0,   1'b0, NO_CHECK},
    '{CMD_READ,      8'h00, 5'd0,  7'd2,   1'b0, NO_CHECK},
    '{CMD_READ,      8'h00, 5'd24, 7'd0,   1'b0, NO_CHECK},
    '{CMD_PUT,       8'h7F, 5'd0,  7'd0,   1'b1, '{5'd1, 7'd1, 8'h00, 8'h00, 1'b0}},
    '{CMD_READ,      8'h00, 5'd1,  7'd127, 1'b1, '{5'd1, 7'd1, 8'h00, 8'h00, 1'b0}}
  };

  text_console_teletype_writer_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .char_code   (char_code),
    .read_row    (read_row),
    .read_col    (read_col),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .cursor_line (cursor_line),
    .cursor_col  (cursor_col),
    .cell_char   (cell_char),
    .cell_color  (cell_color),
    .scrolled    (scrolled)
  );

  always #1 clk = ~clk;

  // Move the cursor down a row; at the bottom roll the screen up instead
  function automatic logic next_line();
    if (cur_row + 1 >= ROWS) begin
      for (int r = FIRST_ROLL; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          screen_copy[(r-1)*COLS + c] = screen_copy[r*COLS + c];
        end
      end
      for (int c = 0; c < COLS; c++) begin
        screen_copy[(ROWS-1)*COLS + c] = {text_attr, BLANK_CODE};
      end
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  // Apply one command to the shadow console and return the reply it gives
  function automatic console_result_t console_step(cmd_t c, logic [7:0] ch,
                                                   logic [4:0] rr, logic [6:0] rc);
    console_result_t r;
    r = '0;
    case (c)
      CMD_PUT: begin
        if (ch == NEWLINE_CODE) begin
          cur_col = 0;
          r.scr = next_line();
        end else begin
          screen_copy[cur_row*COLS + cur_col] = {text_attr, ch};
          if (cur_col + 1 >= COLS) begin
            cur_col = 0;
            r.scr = next_line();
          end else begin
            cur_col++;
          end
        end
      end
      CMD_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
          screen_copy[cur_row*COLS + cur_col] = {text_attr, BLANK_CODE};
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
          screen_copy[cur_row*COLS + cur_col] = {text_attr, BLANK_CODE};
        end
      end
      CMD_READ: begin
        if (rr < ROWS && rc < COLS) {r.attr, r.ch} = screen_copy[rr*COLS + rc];
      end
      default: ;
    endcase
    r.row = 5'(cur_row);
    r.col = 7'(cur_col);
    return r;
  endfunction

  // Offer one command beat; valid stays high afterwards for back-to-back beats
  task automatic offer_item(cmd_t c, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc,
                            logic typed, console_result_t want);
    console_result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    do @(posedge clk); while (cmd_stall);
    got = console_step(c, ch, rr, rc);
    due_replies.push_back(typed ? want : got);
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding reply
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (due_replies.size() != 0);
  endtask

  task automatic set_color(logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    text_attr = v;
    cfg_we    <= 1'b0;
  endtask

  // One random command, or a short run of them (newline bursts, long lines)
  task automatic offer_random();
    int         k;
    int         n;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    k  = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    rr = 5'($urandom_range(0, 31));
    rc = 7'($urandom_range(0, 127));
    if (k < 2) begin
      n = $urandom_range(4, 12);
      repeat (n) offer_item(CMD_PUT, NEWLINE_CODE, rr, rc, 1'b0, NO_CHECK);
    end else if (k < 3) begin
      n = $urandom_range(60, 100);
      repeat (n) offer_item(CMD_PUT, 8'($urandom_range(33, 126)), rr, rc, 1'b0, NO_CHECK);
    end else if (k < 9) begin
      offer_item(CMD_PUT, NEWLINE_CODE, rr, rc, 1'b0, NO_CHECK);
    end else if (k < 19) begin
      offer_item(CMD_BACKSPACE, ch, rr, rc, 1'b0, NO_CHECK);
    end else if (k < 22) begin
      offer_item(CMD_NONE, ch, rr, rc, 1'b0, NO_CHECK);
    end else if (k < 45) begin
      // reads lean towards the cursor and the title row
      n = $urandom_range(0, 9);
      if (n < 4) rr = 5'(cur_row);
      else if (n < 6) rr = 5'd0;
      else if (n < 9) rr = 5'($urandom_range(0, ROWS - 1));
      n = $urandom_range(0, 9);
      if (n < 5) rc = 7'(cur_col > 0 ? cur_col - 1 : 0);
      else if (n < 9) rc = 7'($urandom_range(0, COLS - 1));
      offer_item(CMD_READ, ch, rr, rc, 1'b0, NO_CHECK);
    end else begin
      if ($urandom_range(0, 4) != 0) ch = 8'($urandom_range(33, 126));
      offer_item(CMD_PUT, ch, rr, rc, 1'b0, NO_CHECK);
    end
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct, logic [7:0] color,
                           logic hold_off, logic pause_mid);
    int   start;
    logic paused;
    drain();
    set_color(color);
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < count) begin
      if (hold_off && items_sent - start >= 20) hold_go <= 1'b1;
      if (pause_mid && !paused && items_sent - start >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      offer_random();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      res_stall <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      res_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Reply checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (due_replies.size() == 0) begin
        $display("%0t: reply beat with nothing outstanding (row %0d col %0d)",
                 $time, cursor_line, cursor_col);
        fail_count++;
      end else begin
        reply_want = due_replies.pop_front();
        check_field("cursor_line", reply_want.row, cursor_line);
        check_field("cursor_col", reply_want.col, cursor_col);
        check_field("cell_char", reply_want.ch, cell_char);
        check_field("cell_color", reply_want.attr, cell_color);
        check_field("scrolled", reply_want.scr, scrolled);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d replies outstanding", $time, due_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    foreach (screen_copy[i]) screen_copy[i] = {RESET_COLOR, BLANK_CODE};
    cur_row   = 0;
    cur_col   = 0;
    text_attr = RESET_COLOR;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_color(8'hA5);

    // directed part, no idling on either side
    foreach (probes[i]) begin
      offer_item(probes[i].cmd, probes[i].ch, probes[i].rr, probes[i].rc,
                 probes[i].typed, probes[i].want);
    end

    // random part
    run_phase(130, 0,  0,  8'h00, 1'b0, 1'b0);
    run_phase(130, 65, 0,  8'hFF, 1'b0, 1'b0);
    run_phase(130, 0,  65, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    run_phase(130, 7,  7,  8'($urandom_range(0, 255)), 1'b0, 1'b1);
    run_phase(130, 0,  0,  8'($urandom_range(0, 255)), 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tctw_pkg.sv
hw/rtl/tctw_ram.sv
hw/rtl/tctw_ctrl.sv
hw/rtl/tctw_dp.sv
hw/rtl/text_console_teletype_writer_top.sv
tb/text_console_teletype_writer_top_test.sv
